### sv/lcg48r_pkg.sv
// lcg48r_pkg: shared constants and types for the 48-bit LCG range generator.
// No dependencies; used by every module under sv/.
`timescale 1ns / 1ps

package lcg48r_pkg;

  localparam int SEED_W    = 48;
  localparam int MULT_W    = 35;
  localparam int DRAW_W    = 31;
  localparam int BOUND_W   = 32;
  localparam int VALUE_W   = 32;
  localparam int BCNT_W    = 6;
  localparam int MUL_CNT_W = $clog2(MULT_W);
  localparam int MOD_CNT_W = $clog2(DRAW_W);

  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_INC  = 48'hB;

  // operation codes; code 3 is unused and falls to the default arm
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BITS  = 2'd1,
    OP_RANGE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DRAW,
    S_MOD,
    S_DONE
  } state_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### sv/lcg48r_mul.sv
// lcg48r_mul: serial seed update, seed*LCG_MULT + LCG_INC mod 2^48.
// One multiplier bit per cycle via shift registers. Depends on lcg48r_pkg.
`timescale 1ns / 1ps

module lcg48r_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lcg48r_pkg::SEED_W-1:0]   seed_in,
  output lcg48r_pkg::unit_stat_t          stat,
  output logic [lcg48r_pkg::SEED_W-1:0]   product
);

  logic [lcg48r_pkg::SEED_W-1:0]    mcand_r, mcand_nxt;
  logic [lcg48r_pkg::SEED_W-1:0]    acc_r, acc_nxt;
  logic [lcg48r_pkg::MULT_W-1:0]    mplr_r, mplr_nxt;
  logic [lcg48r_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;

  always_comb begin
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    mplr_nxt  = mplr_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      mcand_nxt = seed_in;
      acc_nxt   = lcg48r_pkg::LCG_INC;   // increment folded in up front
      mplr_nxt  = lcg48r_pkg::LCG_MULT;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (mplr_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      mplr_nxt  = mplr_r >> 1;
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == lcg48r_pkg::MUL_CNT_W'(lcg48r_pkg::MULT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
    mplr_r  <= mplr_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

### sv/lcg48r_mod.sv
// lcg48r_mod: serial restoring remainder of a 31-bit draw by a 32-bit bound.
// One dividend bit per cycle. Depends on lcg48r_pkg.
`timescale 1ns / 1ps

module lcg48r_mod (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lcg48r_pkg::DRAW_W-1:0]   dividend,
  input  logic [lcg48r_pkg::BOUND_W-1:0]  divisor,
  output lcg48r_pkg::unit_stat_t          stat,
  output logic [lcg48r_pkg::BOUND_W-1:0]  remainder
);

  logic [lcg48r_pkg::DRAW_W-1:0]    dvd_r, dvd_nxt;
  logic [lcg48r_pkg::BOUND_W-1:0]   div_r, div_nxt;
  logic [lcg48r_pkg::BOUND_W-1:0]   rem_r, rem_nxt;
  logic [lcg48r_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [lcg48r_pkg::BOUND_W:0]     trial;
  logic [lcg48r_pkg::BOUND_W:0]     diff;

  always_comb begin
    trial     = {rem_r, dvd_r[lcg48r_pkg::DRAW_W-1]};
    diff      = trial - {1'b0, div_r};
    dvd_nxt   = dvd_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder < divisor <= 2^31, so trial never reaches bit 32
      rem_nxt = diff[lcg48r_pkg::BOUND_W] ? trial[lcg48r_pkg::BOUND_W-1:0]
                                          : diff[lcg48r_pkg::BOUND_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lcg48r_pkg::MOD_CNT_W'(lcg48r_pkg::DRAW_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

### sv/lcg48_random_in_range.sv
// lcg48_random_in_range: 48-bit LCG with load seed, next bits and bounded draw.
// From input accept: load seed and the unused op go straight to the done state;
// next bits, power-of-two and above-2^31 draws run the seed multiply, then draw;
// modulo draws add the divider; a rejected draw redoes multiply, draw and modulo.
// One word in flight, next accepted once it is handed out; in_ready high in idle,
// even while a result waits. rst_n (sync, active low) zeroes seed, empties output.
`timescale 1ns / 1ps

module lcg48_random_in_range (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [lcg48r_pkg::SEED_W-1:0]    in_seed_value,
  input  logic [lcg48r_pkg::BCNT_W-1:0]    in_bit_count,
  input  logic [lcg48r_pkg::BOUND_W-1:0]   in_range_bound,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lcg48r_pkg::VALUE_W-1:0]   out_random_value
);

  // control
  lcg48r_pkg::state_t state_r, state_nxt;
  logic                                   out_valid_r, out_valid_nxt;

  // payload
  logic [lcg48r_pkg::SEED_W-1:0]          seed_r, seed_nxt;
  logic [1:0]                             op_r, op_nxt;
  logic [lcg48r_pkg::BCNT_W-1:0]          bcnt_r, bcnt_nxt;
  logic [lcg48r_pkg::BOUND_W-1:0]         bound_r, bound_nxt;
  logic [lcg48r_pkg::DRAW_W-1:0]          u_r, u_nxt;
  logic [lcg48r_pkg::VALUE_W-1:0]         res_r, res_nxt;
  logic [lcg48r_pkg::VALUE_W-1:0]         out_val_r, out_val_nxt;

  // serial units
  logic                                   mul_start;
  lcg48r_pkg::unit_stat_t                 mul_stat;
  logic [lcg48r_pkg::SEED_W-1:0]          mul_product;
  logic                                   mod_start;
  lcg48r_pkg::unit_stat_t                 mod_stat;
  logic [lcg48r_pkg::BOUND_W-1:0]         mod_rem;

  // draw-stage datapath
  logic [lcg48r_pkg::DRAW_W-1:0]          draw;
  logic [lcg48r_pkg::BOUND_W-1:0]         bound_m1;
  logic                                   is_pow2;
  logic                                   over_half;
  logic [lcg48r_pkg::VALUE_W-1:0]         pow_val;
  logic [lcg48r_pkg::BCNT_W-1:0]          nsat;
  logic [lcg48r_pkg::VALUE_W-1:0]         bits_val;
  logic [lcg48r_pkg::BOUND_W-1:0]         bias_chk;

  lcg48r_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .seed_in (seed_r),
    .stat    (mul_stat),
    .product (mul_product)
  );

  lcg48r_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (u_r),
    .divisor   (bound_r),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  // top 31 bits of the freshly advanced seed
  assign draw      = seed_r[lcg48r_pkg::SEED_W-1 -: lcg48r_pkg::DRAW_W];
  assign bound_m1  = bound_r - 1'b1;
  // zero bound also lands here and yields zero
  assign is_pow2   = ((bound_r & bound_m1) == '0);
  assign over_half = bound_r[lcg48r_pkg::BOUND_W-1] &&
                     (bound_r[lcg48r_pkg::BOUND_W-2:0] != '0);
  // draw is biased when u - r + (bound-1) goes negative as int32
  assign bias_chk  = lcg48r_pkg::BOUND_W'(u_r) - mod_rem + bound_m1;

  // power-of-two bound: (bound * draw) >> 31 is a right shift by 31-k
  always_comb begin
    pow_val = '0;
    for (int j = 0; j < lcg48r_pkg::BOUND_W; j++) begin
      if (bound_r[j]) begin
        pow_val = pow_val |
                  (lcg48r_pkg::VALUE_W'(draw) >> (lcg48r_pkg::DRAW_W - j));
      end
    end
  end

  // next bits: count saturates at 32, zero count gives zero
  always_comb begin
    nsat = (bcnt_r > lcg48r_pkg::BCNT_W'(lcg48r_pkg::VALUE_W))
           ? lcg48r_pkg::BCNT_W'(lcg48r_pkg::VALUE_W) : bcnt_r;
    if (bcnt_r == '0) begin
      bits_val = '0;
    end else begin
      bits_val = lcg48r_pkg::VALUE_W'(
                   seed_r >> (lcg48r_pkg::BCNT_W'(lcg48r_pkg::SEED_W) - nsat));
    end
  end

  assign in_ready = (state_r == lcg48r_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    seed_nxt      = seed_r;
    op_nxt        = op_r;
    bcnt_nxt      = bcnt_r;
    bound_nxt     = bound_r;
    u_nxt         = u_r;
    res_nxt       = res_r;
    out_val_nxt   = out_val_r;
    mul_start     = 1'b0;
    mod_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lcg48r_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          bcnt_nxt  = in_bit_count;
          bound_nxt = in_range_bound;
          res_nxt   = '0;
          case (in_operation)
            lcg48r_pkg::OP_LOAD: begin
              seed_nxt  = in_seed_value;
              state_nxt = lcg48r_pkg::S_DONE;
            end
            lcg48r_pkg::OP_BITS,
            lcg48r_pkg::OP_RANGE: begin
              mul_start = 1'b1;
              state_nxt = lcg48r_pkg::S_MUL;
            end
            default: begin
              state_nxt = lcg48r_pkg::S_DONE;   // unused code: no-op, zero word
            end
          endcase
        end
      end

      lcg48r_pkg::S_MUL: begin
        if (mul_stat.done) begin
          seed_nxt  = mul_product;
          state_nxt = lcg48r_pkg::S_DRAW;
        end
      end

      lcg48r_pkg::S_DRAW: begin
        if (op_r == lcg48r_pkg::OP_BITS) begin
          res_nxt   = bits_val;
          state_nxt = lcg48r_pkg::S_DONE;
        end else if (is_pow2) begin
          res_nxt   = pow_val;
          state_nxt = lcg48r_pkg::S_DONE;
        end else if (over_half) begin
          res_nxt   = lcg48r_pkg::VALUE_W'(draw);
          state_nxt = lcg48r_pkg::S_DONE;
        end else begin
          u_nxt     = draw;
          state_nxt = lcg48r_pkg::S_MOD;
        end
      end

      lcg48r_pkg::S_MOD: begin
        // kick the divider on entry, u_r now holds the draw
        if (!mod_stat.busy && !mod_stat.done) begin
          mod_start = 1'b1;
        end
        if (mod_stat.done) begin
          if (bias_chk[lcg48r_pkg::BOUND_W-1]) begin
            mul_start = 1'b1;                  // redraw
            state_nxt = lcg48r_pkg::S_MUL;
          end else begin
            res_nxt   = mod_rem;
            state_nxt = lcg48r_pkg::S_DONE;
          end
        end
      end

      lcg48r_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_val_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lcg48r_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lcg48r_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcg48r_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
    op_r      <= op_nxt;
    bcnt_r    <= bcnt_nxt;
    bound_r   <= bound_nxt;
    u_r       <= u_nxt;
    res_r     <= res_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_val_r;

  // an accepted word always takes the engine out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != lcg48r_pkg::S_IDLE))
    else $error("accepted word did not start work");

  // the multiplier only runs while the FSM waits on it
  a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.busy |-> (state_r == lcg48r_pkg::S_MUL))
    else $error("multiplier busy outside S_MUL");

  // the divider only runs while the FSM waits on it
  a_mod_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.busy |-> (state_r == lcg48r_pkg::S_MOD))
    else $error("divider busy outside S_MOD");

  // a new result word only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == lcg48r_pkg::S_DONE))
    else $error("result word raised outside S_DONE");

endmodule
